/* rtl/core/aes256_pkg.sv */
// ----------------------------------------------------------------------------
// aes256_pkg: shared constants and byte functions for the aes-256 cipher
// s-box tables, gf(2^8) helpers, round and key-schedule step functions
// ----------------------------------------------------------------------------
package aes256_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned KeyWords = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned RoundPairs = 7;

  localparam logic [1:0] CfgKey0 = 2'd0;
  localparam logic [1:0] CfgKey1 = 2'd1;
  localparam logic [1:0] CfgKey2 = 2'd2;
  localparam logic [1:0] CfgKey3 = 2'd3;

  localparam logic OpEnc = 1'b0;
  localparam logic OpDec = 1'b1;

  localparam logic [7:0] Rcon [RoundPairs] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40
  };

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // byte i of a word sits in bits [N*8-1-8i -: 8]
  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    mix_col = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
               xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] u, v;
    logic [31:0] p;
    // premultiply by (04 x^2 + 05), then forward mix
    u = xt(xt(c[31:24] ^ c[15:8]));
    v = xt(xt(c[23:16] ^ c[7:0]));
    p = {c[31:24] ^ u, c[23:16] ^ v, c[15:8] ^ u, c[7:0] ^ v};
    inv_mix_col = mix_col(p);
  endfunction

  function automatic logic [127:0] enc_half(input logic [127:0] s, input logic last);
    logic [127:0] t, m;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = Sbox[s[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[127 - 32 * c -: 32] = mix_col(t[127 - 32 * c -: 32]);
    end
    enc_half = last ? t : m;
  endfunction

  function automatic logic [127:0] dec_half(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] =
          InvSbox[s[127 - 8 * (r + 4 * ((c + 3 * r) & 3)) -: 8]];
      end
    end
    dec_half = t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] m;
    for (int c = 0; c < 4; c++) begin
      m[127 - 32 * c -: 32] = inv_mix_col(s[127 - 32 * c -: 32]);
    end
    inv_mix = m;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  function automatic logic [255:0] key_fwd(input logic [255:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, w4, w5, w6, w7, rw;
    {w0, w1, w2, w3, w4, w5, w6, w7} = k;
    rw = sub_word({w7[23:0], w7[31:24]});
    w0 = w0 ^ rw ^ {rc, 24'h0};
    w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    w4 = w4 ^ sub_word(w3);
    w5 = w5 ^ w4; w6 = w6 ^ w5; w7 = w7 ^ w6;
    key_fwd = {w0, w1, w2, w3, w4, w5, w6, w7};
  endfunction

  function automatic logic [255:0] key_bwd(input logic [255:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, w4, w5, w6, w7, rw;
    {w0, w1, w2, w3, w4, w5, w6, w7} = k;
    w7 = w7 ^ w6; w6 = w6 ^ w5; w5 = w5 ^ w4;
    w4 = w4 ^ sub_word(w3);
    w3 = w3 ^ w2; w2 = w2 ^ w1; w1 = w1 ^ w0;
    rw = sub_word({w7[23:0], w7[31:24]});
    w0 = w0 ^ rw ^ {rc, 24'h0};
    key_bwd = {w0, w1, w2, w3, w4, w5, w6, w7};
  endfunction

endpackage

/* rtl/core/aes256_if.sv */
// ----------------------------------------------------------------------------
// aes256_in_if / aes256_out_if: valid-ready channels of the cipher
// input word carries op and block, result word carries the output block
// ----------------------------------------------------------------------------
interface aes256_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [aes256_pkg::BlockW-1:0] block_hi;
  logic [aes256_pkg::BlockW-1:0] block_lo;
  modport source (output valid, op, block_hi, block_lo, input ready);
  modport sink (input valid, op, block_hi, block_lo, output ready);
endinterface

interface aes256_out_if;
  logic valid;
  logic ready;
  logic [aes256_pkg::BlockW-1:0] out_hi;
  logic [aes256_pkg::BlockW-1:0] out_lo;
  modport source (output valid, out_hi, out_lo, input ready);
  modport sink (input valid, out_hi, out_lo, output ready);
endinterface

/* rtl/core/aes256_block_cipher.sv */
// encrypt: load, then 14 half-round steps; decrypt: load, then 7 forward
// key-schedule steps, then 14 half-round steps
// one round (half of a double-round pair) per cycle through a shared round unit
// one word in flight; a new word is accepted only after the result has been
// taken with out_ch.ready
// rst_n synchronous active low: key registers clear to zero, sequencer to idle
// ----------------------------------------------------------------------------
// aes256_block_cipher: iterative aes-256 encrypt / decrypt
// shared round unit with on-the-fly key expansion, forward and backward
// ----------------------------------------------------------------------------
module aes256_block_cipher (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [aes256_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [aes256_pkg::BlockW-1:0]     cfg_data,
  aes256_in_if.sink                         in_ch,
  aes256_out_if.source                      out_ch
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StKey  = 2'd1;
  localparam logic [1:0] StRnd  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]   state_r, state_nxt;
  logic [255:0] key_r;
  logic [255:0] rk_r, rk_nxt;
  logic [127:0] s_r, s_nxt;
  logic         op_r;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [2:0]   pair;
  logic [127:0] half_out;
  logic [255:0] kf, kb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes256_pkg::CfgKey0: key_r[255:192] <= cfg_data;
        aes256_pkg::CfgKey1: key_r[191:128] <= cfg_data;
        aes256_pkg::CfgKey2: key_r[127:64]  <= cfg_data;
        aes256_pkg::CfgKey3: key_r[63:0]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // in StRnd cnt counts half rounds 0..13 (key steps 0..6 in StKey); pair index is cnt/2 (encrypt) or 6-cnt/2 (decrypt)
  assign pair = op_r ? 3'(3'd6 - cnt_r[3:1]) : cnt_r[3:1];
  assign kf = aes256_pkg::key_fwd(rk_r, aes256_pkg::Rcon[op_r ? cnt_r[2:0] : pair]);
  assign kb = aes256_pkg::key_bwd(rk_r, aes256_pkg::Rcon[pair]);

  always_comb begin
    half_out = '0;
    rk_nxt = rk_r;
    if (!op_r) begin
      half_out = aes256_pkg::enc_half(s_r, cnt_r == 4'd13);
      if (!cnt_r[0]) begin
        half_out = half_out ^ rk_r[127:0];
      end else begin
        rk_nxt = kf;
        half_out = half_out ^ kf[255:128];
      end
    end else begin
      if (!cnt_r[0]) begin
        rk_nxt = kb;
        half_out = aes256_pkg::inv_mix(aes256_pkg::dec_half(s_r) ^ kb[127:0]);
      end else begin
        half_out = aes256_pkg::dec_half(s_r) ^ rk_r[255:128];
        if (cnt_r != 4'd13) half_out = aes256_pkg::inv_mix(half_out);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    s_nxt = s_r;
    unique case (state_r)
      StIdle: begin
        cnt_nxt = '0;
      end
      StKey: begin
        cnt_nxt = 4'(cnt_r + 4'd1);
        if (cnt_r == 4'(aes256_pkg::RoundPairs - 1)) begin
          cnt_nxt = '0;
          state_nxt = StRnd;
          s_nxt = s_r ^ kf[255:128];
        end
      end
      StRnd: begin
        s_nxt = half_out;
        cnt_nxt = 4'(cnt_r + 4'd1);
        if (cnt_r == 4'd13) state_nxt = StDone;
      end
      StDone: begin
        if (out_ch.ready) state_nxt = StIdle;
      end
      default: state_nxt = StIdle;
    endcase
    if (state_r == StIdle && in_ch.valid) begin
      state_nxt = in_ch.op ? StKey : StRnd;
      s_nxt = {in_ch.block_hi, in_ch.block_lo} ^ (in_ch.op ? 128'h0 : key_r[255:128]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    if (state_r == StIdle && in_ch.valid) begin
      op_r <= in_ch.op;
      rk_r <= key_r;
    end else if (state_r == StKey) begin
      rk_r <= kf;
    end else if (state_r == StRnd) begin
      rk_r <= rk_nxt;
    end
  end

  assign in_ch.ready = (state_r == StIdle);
  assign out_ch.valid = (state_r == StDone);
  assign out_ch.out_hi = s_r[127:64];
  assign out_ch.out_lo = s_r[63:0];

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(s_r))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != StIdle |-> !in_ch.ready)
    else $error("ready while busy");
  a_key_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == StKey |-> cnt_r < 4'(aes256_pkg::RoundPairs))
    else $error("key expansion overran");
  a_rnd_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == StRnd && cnt_r == 4'd13 |=> state_r == StDone)
    else $error("round count slip");

endmodule
